@@ rtl/stok_pkg.sv @@
// Shared types, constants and helpers for the script tokenizer.
package stok_pkg;

    localparam int MAX_TOKEN  = 1024;
    localparam int LINE_BITS  = 16;
    localparam int LEN_BITS   = $clog2(MAX_TOKEN);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam logic [LEN_BITS-1:0]  LEN_LIMIT = LEN_BITS'(MAX_TOKEN - 1);
    localparam logic [LINE_BITS-1:0] LINE_MAX  = '1;
    localparam logic [LINE_BITS-1:0] LINE_ONE  = LINE_BITS'(1);

    localparam logic [7:0] CH_EOD   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_QUOTE_EOD = 2'd2;
    localparam logic [1:0] ST_END       = 2'd3;

    typedef enum logic [4:0] {
        MODE_BETWEEN = 5'b00001,
        MODE_PLAIN   = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_QUOTED  = 5'b01000,
        MODE_DISCARD = 5'b10000
    } scan_mode_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        crossed_line;
        logic [15:0] start_line;
        logic        token_last;
        logic        token_first;
        logic        has_byte;
        logic [7:0]  out_byte;
    } out_item_t;

    // Line number as reported, saturating at 16 bits.
    function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] line);
        logic [31:0] wide;
        wide = 32'(line);
        return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
    endfunction

    function automatic out_item_t mk_item(
        input logic [7:0]           byte_val,
        input logic                 has,
        input logic                 first,
        input logic                 last,
        input logic [LINE_BITS-1:0] line,
        input logic                 crossed,
        input logic [1:0]           status
    );
        out_item_t item;
        item.out_byte     = has ? byte_val : 8'h00;
        item.has_byte     = has;
        item.token_first  = first;
        item.token_last   = last;
        item.start_line   = sat_line(line);
        item.crossed_line = crossed;
        item.status       = status;
        return item;
    endfunction

endpackage

@@ rtl/script_tokenizer_unit.sv @@
// Script tokenizer: splits a byte stream into tokens with line tracking.
//
// Input channel s_axis: one script byte per request in tdata[7:0]; byte 0 ends
// the stream. Output channel m_axis: one result per request; tdata carries the
// token byte and the start line, tuser the has-byte, first, crossed-line and
// status flags, tlast marks the last result of a token.
// A byte is taken into the input register and, once the result queue has room,
// scanned into that queue; its results are then visible on m_axis.
// Throughput is one byte per cycle while the queue has room; a byte that yields
// two results (a token ended by byte 0 or cut short by an error) puts both into
// a four-entry result queue, which the single result port drains one at a time.
// Scanning stops while the queue holds more than two results, so a stalled
// receiver backs up into s_axis_tready without losing anything.
// Reset, and the end of every stream, return the scanner to between tokens
// with the line count at one; no clearing pass is needed.
module script_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] start_line
    output logic        m_axis_tlast,
    output logic [4:0]  m_axis_tuser    // [0] has_byte, [1] token_first,
                                        // [2] crossed_line, [4:3] status
);
    import stok_pkg::*;

    // input register
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;

    // scanner state
    scan_mode_t            mode_reg, mode_next;
    logic [7:0]            held_byte_reg, held_byte_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  maybe_comment_reg, maybe_comment_next;
    logic [LEN_BITS-1:0]   token_len_reg, token_len_next;
    logic [LINE_BITS-1:0]  line_count_reg, line_count_next;
    logic [LINE_BITS-1:0]  token_line_reg, token_line_next;
    logic                  newline_seen_reg, newline_seen_next;
    logic                  first_pending_reg, first_pending_next;

    // result queue
    out_item_t             fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;

    logic                  step_fire;
    logic                  pop;
    out_item_t             res0, res1;
    logic [1:0]            step_cnt;

    assign step_fire     = in_valid_reg && (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_comb
    begin
        logic [7:0] b;
        logic       is_sep;
        logic       do_reset;
        out_item_t  send_mid;
        out_item_t  send_end;

        b        = in_byte_reg;
        is_sep   = (b <= CH_SPACE);
        do_reset = 1'b0;

        mode_next          = mode_reg;
        held_byte_next     = held_byte_reg;
        held_valid_next    = held_valid_reg;
        maybe_comment_next = maybe_comment_reg;
        token_len_next     = token_len_reg;
        line_count_next    = line_count_reg;
        token_line_next    = token_line_reg;
        newline_seen_next  = newline_seen_reg;
        first_pending_next = first_pending_reg;
        res0               = '0;
        res1               = '0;
        step_cnt           = 2'd0;

        // held byte (or empty token) sent as token data
        send_mid = mk_item(held_byte_reg, held_valid_reg, first_pending_reg, 1'b0,
                           token_line_reg, first_pending_reg && newline_seen_reg, ST_DATA);
        send_end = send_mid;
        send_end.token_last = 1'b1;

        unique case (mode_reg)
            MODE_PLAIN:
            begin
                maybe_comment_next = 1'b0;
                if (maybe_comment_reg && b == CH_SLASH)
                begin
                    held_valid_next    = 1'b0;
                    first_pending_next = 1'b0;
                    newline_seen_next  = 1'b1;
                    mode_next          = MODE_COMMENT;
                end
                else if (is_sep)
                begin
                    res0            = send_end;
                    step_cnt        = 2'd1;
                    held_valid_next = 1'b0;
                    if (first_pending_reg)
                    begin
                        newline_seen_next  = 1'b0;
                        first_pending_next = 1'b0;
                    end
                    mode_next = MODE_BETWEEN;
                    if (b == CH_EOD)
                    begin
                        res1     = mk_item(8'h00, 1'b0, 1'b0, 1'b0, line_count_reg,
                                           1'b0, ST_END);
                        step_cnt = 2'd2;
                        do_reset = 1'b1;
                    end
                    else if (b == CH_NL)
                    begin
                        if (line_count_reg != LINE_MAX)
                        begin
                            line_count_next = line_count_reg + LINE_ONE;
                        end
                        newline_seen_next = 1'b1;
                    end
                end
                else if (token_len_reg >= LEN_LIMIT)
                begin
                    // plain tokens always hold a byte here
                    res0               = send_mid;
                    res1               = mk_item(8'h00, 1'b0, 1'b0, 1'b1, token_line_reg,
                                                 1'b0, ST_TOO_LONG);
                    step_cnt           = 2'd2;
                    held_valid_next    = 1'b0;
                    first_pending_next = 1'b0;
                    if (first_pending_reg)
                    begin
                        newline_seen_next = 1'b0;
                    end
                    mode_next = MODE_DISCARD;
                end
                else
                begin
                    token_len_next  = token_len_reg + LEN_BITS'(1);
                    res0            = send_mid;
                    step_cnt        = {1'b0, held_valid_reg};
                    if (held_valid_reg && first_pending_reg)
                    begin
                        newline_seen_next  = 1'b0;
                        first_pending_next = 1'b0;
                    end
                    held_byte_next  = b;
                    held_valid_next = 1'b1;
                end
            end
            MODE_QUOTED:
            begin
                if (b == CH_EOD)
                begin
                    if (held_valid_reg)
                    begin
                        res0     = send_mid;
                        res1     = mk_item(8'h00, 1'b0, 1'b0, 1'b1, token_line_reg,
                                           1'b0, ST_QUOTE_EOD);
                        step_cnt = 2'd2;
                    end
                    else
                    begin
                        res0     = mk_item(8'h00, 1'b0, 1'b0, 1'b1, token_line_reg,
                                           1'b0, ST_QUOTE_EOD);
                        step_cnt = 2'd1;
                    end
                    do_reset = 1'b1;
                end
                else if (b == CH_QUOTE)
                begin
                    res0            = send_end;
                    step_cnt        = 2'd1;
                    held_valid_next = 1'b0;
                    if (first_pending_reg)
                    begin
                        newline_seen_next  = 1'b0;
                        first_pending_next = 1'b0;
                    end
                    mode_next = MODE_BETWEEN;
                end
                else
                begin
                    if (b == CH_NL && line_count_reg != LINE_MAX)
                    begin
                        line_count_next = line_count_reg + LINE_ONE;
                    end
                    if (held_valid_reg && first_pending_reg)
                    begin
                        newline_seen_next  = 1'b0;
                        first_pending_next = 1'b0;
                    end
                    if (token_len_reg >= LEN_LIMIT)
                    begin
                        if (held_valid_reg)
                        begin
                            res0     = send_mid;
                            res1     = mk_item(8'h00, 1'b0, 1'b0, 1'b1, token_line_reg,
                                               1'b0, ST_TOO_LONG);
                            step_cnt = 2'd2;
                        end
                        else
                        begin
                            res0     = mk_item(8'h00, 1'b0, 1'b0, 1'b1, token_line_reg,
                                               1'b0, ST_TOO_LONG);
                            step_cnt = 2'd1;
                        end
                        held_valid_next    = 1'b0;
                        maybe_comment_next = 1'b0;
                        mode_next          = MODE_DISCARD;
                    end
                    else
                    begin
                        token_len_next  = token_len_reg + LEN_BITS'(1);
                        res0            = send_mid;
                        step_cnt        = {1'b0, held_valid_reg};
                        held_byte_next  = b;
                        held_valid_next = 1'b1;
                    end
                end
            end
            MODE_COMMENT:
            begin
                if (b == CH_EOD)
                begin
                    res0     = mk_item(8'h00, 1'b0, 1'b0, 1'b0, line_count_reg, 1'b0, ST_END);
                    step_cnt = 2'd1;
                    do_reset = 1'b1;
                end
                else if (b == CH_NL)
                begin
                    if (line_count_reg != LINE_MAX)
                    begin
                        line_count_next = line_count_reg + LINE_ONE;
                    end
                    newline_seen_next = 1'b1;
                    mode_next         = MODE_BETWEEN;
                end
            end
            MODE_DISCARD:
            begin
                if (b == CH_EOD)
                begin
                    res0     = mk_item(8'h00, 1'b0, 1'b0, 1'b0, line_count_reg, 1'b0, ST_END);
                    step_cnt = 2'd1;
                    do_reset = 1'b1;
                end
            end
            default:
            begin
                // between tokens; stray codes land here too
                mode_next = MODE_BETWEEN;
                if (is_sep)
                begin
                    if (b == CH_EOD)
                    begin
                        res0     = mk_item(8'h00, 1'b0, 1'b0, 1'b0, line_count_reg,
                                           1'b0, ST_END);
                        step_cnt = 2'd1;
                        do_reset = 1'b1;
                    end
                    else if (b == CH_NL)
                    begin
                        if (line_count_reg != LINE_MAX)
                        begin
                            line_count_next = line_count_reg + LINE_ONE;
                        end
                        newline_seen_next = 1'b1;
                    end
                end
                else
                begin
                    token_line_next    = line_count_reg;
                    first_pending_next = 1'b1;
                    if (b == CH_QUOTE)
                    begin
                        held_valid_next    = 1'b0;
                        token_len_next     = '0;
                        maybe_comment_next = 1'b0;
                        mode_next          = MODE_QUOTED;
                    end
                    else
                    begin
                        held_byte_next     = b;
                        held_valid_next    = 1'b1;
                        token_len_next     = LEN_BITS'(1);
                        maybe_comment_next = (b == CH_SLASH);
                        mode_next          = MODE_PLAIN;
                    end
                end
            end
        endcase

        if (do_reset)
        begin
            mode_next          = MODE_BETWEEN;
            held_byte_next     = 8'h00;
            held_valid_next    = 1'b0;
            maybe_comment_next = 1'b0;
            token_len_next     = '0;
            line_count_next    = LINE_ONE;
            token_line_next    = LINE_ONE;
            newline_seen_next  = 1'b0;
            first_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_BETWEEN;
            held_byte_reg     <= 8'h00;
            held_valid_reg    <= 1'b0;
            maybe_comment_reg <= 1'b0;
            token_len_reg     <= '0;
            line_count_reg    <= LINE_ONE;
            token_line_reg    <= LINE_ONE;
            newline_seen_reg  <= 1'b0;
            first_pending_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            mode_reg          <= mode_next;
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
            maybe_comment_reg <= maybe_comment_next;
            token_len_reg     <= token_len_next;
            line_count_reg    <= line_count_next;
            token_line_reg    <= token_line_next;
            newline_seen_reg  <= newline_seen_next;
            first_pending_reg <= first_pending_next;
        end
    end

    // result queue: up to two writes, one read per cycle
    always_ff @(posedge clk)
    begin
        if (step_fire && step_cnt != 2'd0)
        begin
            fifo_mem_reg[wr_ptr_reg] <= res0;
        end
        if (step_fire && step_cnt == 2'd2)
        begin
            fifo_mem_reg[wr_ptr_reg + PTR_BITS'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (step_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(step_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            count_reg <= count_reg + (step_fire ? CNT_BITS'(step_cnt) : '0)
                         - CNT_BITS'(pop);
        end
    end

    out_item_t head;
    assign head          = fifo_mem_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {head.start_line, head.out_byte};
    assign m_axis_tlast  = head.token_last;
    assign m_axis_tuser  = {head.status, head.crossed_line, head.token_first, head.has_byte};

`ifndef SYNTHESIS
    a_held_in_token: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (mode_reg == MODE_PLAIN || mode_reg == MODE_QUOTED))
        else $error("held byte outside a token");

    a_plain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PLAIN) |-> held_valid_reg)
        else $error("plain token without a held byte");

    a_slash_plain: assert property (@(posedge clk) disable iff (!rst_n)
        maybe_comment_reg |-> (mode_reg == MODE_PLAIN))
        else $error("comment lookahead outside a plain token");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> (count_reg <= CNT_BITS'(FIFO_DEPTH)))
        else $error("result queue overflow");
`endif

endmodule
